// ----- rtl/cholesky_factorization_core_assert.svh -----
// Assertion macros for the Cholesky factorization core.
`ifndef CHOLESKY_FACTORIZATION_CORE_ASSERT_SVH
`define CHOLESKY_FACTORIZATION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CHF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CHF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CHF_ASSERT_IMPL(label, ante, cons)
`define CHF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/chf_pkg.sv -----
// Shared types and constants of the Cholesky factorization core.
package chf_pkg;
    localparam int MAX_ORDER = 8;
    localparam int IDX_BITS = 3;
    localparam int ADDR_BITS = 6;
    localparam logic [3:0] ORDER_RESET = 4'd4;

    typedef enum logic [2:0]
    {
        OP_NONE = 3'd0,
        OP_LOAD = 3'd1,
        OP_MAC  = 3'd2,
        OP_DIV  = 3'd3,
        OP_SQRT = 3'd4,
        OP_EMIT = 3'd5
    } dp_op_t;

    typedef struct packed
    {
        dp_op_t               op;
        logic [IDX_BITS-1:0]  i;
        logic [IDX_BITS-1:0]  j;
        logic [IDX_BITS-1:0]  k;
        logic                 first;
        logic                 last;
    } dp_cmd_t;

    typedef struct packed
    {
        logic done;
        logic out_full;
    } dp_status_t;
endpackage

// ----- rtl/chf_datapath.sv -----
// Datapath: element store, multiply-accumulate, divider, square root and output register.
module chf_datapath
    import chf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    input  logic                 cmd_valid,
    input  logic signed [31:0]   load_data,
    input  logic                 store_en,
    input  logic                 out_take,
    output dp_status_t           status,
    output logic [39:0]          out_data
);
    logic signed [31:0] mem [MAX_ORDER*MAX_ORDER];
    logic signed [31:0] ra_reg;
    logic signed [31:0] rb_reg;
    logic [1:0]         phase_reg;
    logic [1:0]         phase_next;
    logic signed [65:0] acc_reg;
    logic               err_reg;
    logic               out_full_reg;
    logic [39:0]        out_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        num_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        q_reg;
    logic               neg_reg;
    logic signed [63:0] prod;
    logic signed [63:0] prod_t;
    logic [ADDR_BITS-1:0] addr_a;
    logic [ADDR_BITS-1:0] addr_b;
    logic [ADDR_BITS-1:0] addr_w;
    logic signed [65:0] lim;
    logic signed [65:0] acc_c;
    logic signed [65:0] acc_full;
    logic signed [65:0] acc_fc;
    logic signed [65:0] acc_abs;
    logic [64:0]        trial;
    logic [64:0]        rem_sh;
    logic signed [31:0] wr_val;
    logic               wr_en;

    assign lim = 66'sd140737488355327;
    assign addr_w = {cmd.i, cmd.j};
    always_comb
    begin
        addr_a = {cmd.i, cmd.k};
        addr_b = {cmd.j, cmd.k};
        if (cmd.op == OP_DIV || cmd.op == OP_SQRT)
        begin
            addr_a = {cmd.i, cmd.j};
            addr_b = {cmd.j, cmd.j};
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg <= mem[addr_a];
        rb_reg <= mem[addr_b];
        if (store_en)
            mem[addr_w] <= load_data;
        else if (wr_en)
            mem[addr_w] <= wr_val;
    end

    assign prod = ra_reg * rb_reg;
    assign prod_t = (prod < 0) ? -((-prod) >>> 16) : (prod >>> 16);
    always_comb
    begin
        acc_c = acc_reg;
        if (acc_c > lim) acc_c = lim;
        if (acc_c < -lim) acc_c = -lim;
    end

    always_comb
    begin
        acc_full = 66'(signed'(ra_reg));
        if (!cmd.first)
            acc_full = acc_full + acc_reg;
        acc_fc = acc_full;
        if (acc_fc > lim) acc_fc = lim;
        if (acc_fc < -lim) acc_fc = -lim;
        acc_abs = (acc_fc < 0) ? -acc_fc : acc_fc;
    end

    assign rem_sh = {rem_reg, num_reg[63]};
    assign trial = (cmd.op == OP_SQRT) ? {rem_reg[62:0], num_reg[63:62]} : rem_sh;

    always_comb
    begin
        phase_next = phase_reg;
        wr_en = 1'b0;
        wr_val = '0;
        if (cmd_valid)
        begin
            unique case (phase_reg)
                2'd0: phase_next = 2'd1;
                2'd1: phase_next = (cmd.op == OP_MAC || cmd.op == OP_EMIT) ? 2'd0 : 2'd2;
                2'd2: phase_next = (cnt_reg == 6'd0) ? 2'd3 : 2'd2;
                2'd3:
                begin
                    phase_next = 2'd0;
                    wr_en = 1'b1;
                    if (cmd.op == OP_SQRT)
                        wr_val = (acc_reg <= 0) ? 32'sd0 :
                            ((q_reg > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q_reg[31:0]);
                    else if (rb_reg == 0)
                        wr_val = (acc_c > 0) ? 32'sh7FFFFFFF :
                            ((acc_c < 0) ? 32'sh80000000 : 32'sd0);
                    else if (q_reg > (neg_reg ? 64'h80000000 : 64'h7FFFFFFF))
                        wr_val = neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
                    else
                        wr_val = neg_reg ? -q_reg[31:0] : q_reg[31:0];
                end
                default: phase_next = 2'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            err_reg <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (out_take)
                out_full_reg <= 1'b0;
            if (cmd_valid && phase_reg == 2'd1 && cmd.op == OP_EMIT)
                out_full_reg <= 1'b1;
            if (wr_en && ((cmd.op == OP_SQRT && acc_reg <= 0) ||
                (cmd.op == OP_DIV && rb_reg == 0)))
                err_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && phase_reg == 2'd1)
        begin
            unique case (cmd.op)
                OP_MAC:
                    acc_reg <= (cmd.first ? 66'sd0 : acc_reg) - 66'(prod_t);
                OP_DIV:
                begin
                    acc_reg <= acc_fc;
                    cnt_reg <= 6'd63;
                    rem_reg <= '0;
                    q_reg <= '0;
                    neg_reg <= (acc_fc < 0) ^ rb_reg[31];
                    num_reg <= {acc_abs[47:0], 16'd0};
                end
                OP_SQRT:
                begin
                    acc_reg <= acc_full;
                    cnt_reg <= 6'd31;
                    rem_reg <= '0;
                    q_reg <= '0;
                    num_reg <= {acc_full[47:0], 16'd0};
                end
                OP_EMIT:
                    out_reg <= {err_reg, cmd.last, cmd.k, cmd.i,
                        (cmd.k > cmd.j) ? 32'd0 : ra_reg};
                default: ;
            endcase
        end
        else if (cmd_valid && phase_reg == 2'd2)
        begin
            if (cnt_reg != 6'd0)
                cnt_reg <= cnt_reg - 6'd1;
            if (cmd.op == OP_SQRT)
            begin
                num_reg <= num_reg << 2;
                if (trial >= 65'({q_reg[62:0], 2'b01}))
                begin
                    rem_reg <= 64'(trial - 65'({q_reg[62:0], 2'b01}));
                    q_reg <= {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[63:0];
                    q_reg <= {q_reg[62:0], 1'b0};
                end
            end
            else
            begin
                num_reg <= num_reg << 1;
                if (rem_sh >= 65'(rb_reg[31] ? -64'(rb_reg) : 64'(rb_reg)))
                begin
                    rem_reg <= 64'(rem_sh - 65'(rb_reg[31] ? -64'(rb_reg) : 64'(rb_reg)));
                    q_reg <= {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[63:0];
                    q_reg <= {q_reg[62:0], 1'b0};
                end
            end
        end
    end

    assign status.done = cmd_valid && ((phase_reg == 2'd1 &&
        (cmd.op == OP_MAC || cmd.op == OP_EMIT)) || phase_reg == 2'd3);
    assign status.out_full = out_full_reg;
    assign out_data = out_reg;
endmodule

// ----- rtl/chf_controller.sv -----
// Controller: load counting and sequencing of the factorization and output.
module chf_controller
    import chf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        store_en,
    output logic [IDX_BITS-1:0] ld_row,
    output logic [IDX_BITS-1:0] ld_col,
    input  dp_status_t  status,
    output dp_cmd_t     cmd,
    output logic        cmd_valid
);
    typedef enum logic [3:0]
    {
        ST_LOAD = 4'b0001,
        ST_CALC = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_WAIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] order_reg;
    logic [3:0] n;
    logic [3:0] r_reg, c_reg;
    logic [3:0] i_reg, j_reg, k_reg;
    logic [3:0] i_next, j_next, k_next;
    logic       step_done;
    logic       last_load;

    always_comb
    begin
        n = order_reg;
        if (n == 4'd0) n = 4'd1;
        if (n > 4'd8) n = 4'd8;
    end

    assign in_ready = (state_reg == ST_LOAD) && !cfg_we;
    assign store_en = in_valid && in_ready && (c_reg <= r_reg);
    assign ld_row = r_reg[2:0];
    assign ld_col = c_reg[2:0];
    assign last_load = (r_reg == n - 4'd1) && (c_reg == n - 4'd1);

    always_comb
    begin
        cmd.i = i_reg[2:0];
        cmd.j = j_reg[2:0];
        cmd.k = k_reg[2:0];
        cmd.first = (k_reg == 4'd0);
        cmd.last = (i_reg == n - 4'd1) && (k_reg == n - 4'd1);
        cmd.op = OP_NONE;
        if (state_reg == ST_CALC)
        begin
            if (k_reg < j_reg) cmd.op = OP_MAC;
            else cmd.op = (i_reg == j_reg) ? OP_SQRT : OP_DIV;
        end
        else if (state_reg == ST_EMIT)
            cmd.op = OP_EMIT;
        if (state_reg == ST_EMIT)
        begin
            cmd.j = i_reg[2:0];
            cmd.first = 1'b0;
        end
    end

    assign cmd_valid = (state_reg == ST_CALC) || (state_reg == ST_EMIT && !status.out_full);
    assign step_done = status.done;

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        unique case (state_reg)
            ST_LOAD:
                if (in_valid && in_ready && last_load)
                begin
                    state_next = ST_CALC;
                    i_next = '0;
                    j_next = '0;
                    k_next = '0;
                end
            ST_CALC:
                if (step_done)
                begin
                    if (k_reg < j_reg && !(k_reg == j_reg - 4'd1 && 1'b0))
                        k_next = k_reg + 4'd1;
                    else if (j_reg < i_reg)
                    begin
                        j_next = j_reg + 4'd1;
                        k_next = '0;
                    end
                    else if (i_reg < n - 4'd1)
                    begin
                        i_next = i_reg + 4'd1;
                        j_next = '0;
                        k_next = '0;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                        i_next = '0;
                        k_next = '0;
                    end
                end
            ST_EMIT:
                if (step_done)
                begin
                    if (k_reg < n - 4'd1)
                        k_next = k_reg + 4'd1;
                    else if (i_reg < n - 4'd1)
                    begin
                        i_next = i_reg + 4'd1;
                        k_next = '0;
                    end
                    else
                        state_next = ST_WAIT;
                end
            ST_WAIT:
                if (!status.out_full)
                    state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            order_reg <= ORDER_RESET;
            r_reg <= '0;
            c_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            if (cfg_we)
            begin
                order_reg <= cfg_data;
                r_reg <= '0;
                c_reg <= '0;
            end
            else if (in_valid && in_ready)
            begin
                if (last_load)
                begin
                    r_reg <= '0;
                    c_reg <= '0;
                end
                else if (c_reg == n - 4'd1)
                begin
                    r_reg <= r_reg + 4'd1;
                    c_reg <= '0;
                end
                else
                    c_reg <= c_reg + 4'd1;
            end
        end
    end
endmodule

// ----- rtl/cholesky_factorization_core.sv -----
// Top level of the Cholesky factorization core.
// The slave channel takes matrix elements (signed Q16.16) in row-major order,
// one word per accepted beat; words above the diagonal are dropped.
// The configuration port sets the matrix order (1 to 8); a write restarts loading.
// After the last element the block factors the matrix with one shared
// multiply-accumulate, a bit-serial divider and a bit-serial square root,
// all reading a single element store.
// The master channel then gives all n*n factor words row-major; tlast marks the last
// word. The next word is read out only once the receiver has taken the one before.
// While factoring or sending, and during a configuration write,
// s_axis_tready is low.
// A stalled master channel holds its word; the block waits.
// Reset clears the load position, the sticky error flag, and sets order 4.
module cholesky_factorization_core
    import chf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // element_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // factor_value, row_index, column_index
    output logic        m_axis_tlast,   // last_element
    output logic        m_axis_tuser    // not_positive_definite
);
`include "cholesky_factorization_core_assert.svh"
    dp_cmd_t    cmd;
    logic       cmd_valid;
    dp_status_t status;
    logic       store_en;
    logic [IDX_BITS-1:0] ld_row, ld_col;
    logic [39:0] od;
    dp_cmd_t    dcmd;

    chf_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .store_en(store_en),
        .ld_row(ld_row), .ld_col(ld_col), .status(status),
        .cmd(cmd), .cmd_valid(cmd_valid)
    );

    always_comb
    begin
        dcmd = cmd;
        if (store_en)
        begin
            dcmd.i = ld_row;
            dcmd.j = ld_col;
        end
    end

    chf_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(dcmd), .cmd_valid(cmd_valid),
        .load_data(s_axis_tdata), .store_en(store_en),
        .out_take(m_axis_tvalid && m_axis_tready), .status(status), .out_data(od)
    );

    assign m_axis_tvalid = status.out_full;
    assign m_axis_tdata = {2'b00, od[37:0]};
    assign m_axis_tlast = od[38];
    assign m_axis_tuser = od[39];

    `CHF_ASSERT_IMPL(a_ready_no_output, s_axis_tready, !m_axis_tvalid)
    `CHF_ASSERT_NEXT(a_output_held, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `CHF_ASSERT_NEXT(a_err_sticky, m_axis_tvalid && m_axis_tuser,
        !m_axis_tvalid || m_axis_tuser)
endmodule
